// ----- rtl/event_table_producer_consumer_macros.svh -----
// Assertion macros for the event table block
`ifndef EVENT_TABLE_PRODUCER_CONSUMER_MACROS_SVH
`define EVENT_TABLE_PRODUCER_CONSUMER_MACROS_SVH
// Check that an implication holds on every clock edge out of reset
`define ETPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that an implication holds in the cycle after the antecedent
`define ETPC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/etpc_pkg.sv -----
// ----------------------------------------------------------------------------
// etpc_pkg
// Types and codes shared by the event table block.
// ----------------------------------------------------------------------------
package etpc_pkg;
	typedef enum logic [2:0] {
		CMD_TICK = 3'd0, CMD_PRODUCE = 3'd1, CMD_WR_PROD = 3'd2, CMD_WR_CONS = 3'd3,
		CMD_ID_CONS = 3'd4, CMD_ID_PROD = 3'd5, CMD_ID_EVENTS = 3'd6, CMD_REPORT = 3'd7
	} cmd_t;
	typedef enum logic [1:0] {
		MSG_PROD_ID = 2'd0, MSG_REPORT = 2'd1, MSG_CONS_ID = 2'd2, MSG_NOTIFY = 2'd3
	} msg_kind_t;
	typedef enum logic [1:0] {
		REG_NODE_ID = 2'd0, REG_PROD_CNT = 2'd1, REG_CONS_CNT = 2'd2
	} reg_idx_t;
	typedef enum logic [3:0] {
		ST_IDLE, ST_PSCAN, ST_PREAD, ST_CSCAN, ST_CREAD, ST_FIND, ST_FCHK, ST_MARK,
		ST_OUT1, ST_OUT2
	} state_t;
endpackage

// ----- rtl/event_table_producer_consumer.sv -----
// Write, produce and identify-events transactions complete when accepted; a tick
// scans the producer table and, if tx_ready was set, the consumer table up to the
// first flagged entry, one entry per cycle; a match reads, then compares, each entry.
// One transaction is held at a time; in_ready is low while it is worked.
// arst_n clears flags, scan pointers and registers; identifier tables
// read as zero until written (valid bits per entry).
// ----------------------------------------------------------------------------
// event_table_producer_consumer
// Producer and consumer event identifier tables with scan and match logic.
// ----------------------------------------------------------------------------
`include "event_table_producer_consumer_macros.svh"
module event_table_producer_consumer #(
	parameter int MAX_PRODUCED = 32,
	parameter int MAX_CONSUMED = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [4:0]  entry_index,
	input  logic [63:0] event_id,
	input  logic [47:0] frame_node_id,
	input  logic        tx_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  message_kind,
	output logic [4:0]  message_index,
	output logic [63:0] message_event,
	output logic        last
);
	localparam int PW = (MAX_PRODUCED > 1) ? $clog2(MAX_PRODUCED) : 1;
	localparam int CW = (MAX_CONSUMED > 1) ? $clog2(MAX_CONSUMED) : 1;
	localparam int PS = $clog2(MAX_PRODUCED + 1);
	localparam int CS = $clog2(MAX_CONSUMED + 1);

	logic [63:0] prod_mem [MAX_PRODUCED];
	logic [63:0] cons_mem [MAX_CONSUMED];
	logic [MAX_PRODUCED-1:0] p_val_q, p_id_q, p_rep_q;
	logic [MAX_CONSUMED-1:0] c_val_q, c_id_q;
	logic [PS-1:0] pscan_q, np;
	logic [CS-1:0] cscan_q, nc;
	logic [47:0] node_q;
	logic [5:0] pcnt_q, ccnt_q;

	etpc_pkg::state_t state_q, state_d;
	etpc_pkg::cmd_t cmd_q;
	logic [63:0] ev_q, rd_q;
	logic tx_q, rd_v_q;
	logic [8:0] ptr_q; // walk pointer for match
	logic have1_q, have2_q;
	logic [1:0] k1_q, k2_q;
	logic [4:0] i1_q, i2_q;
	logic [63:0] e1_q, e2_q;

	assign np = (32'(pcnt_q) > MAX_PRODUCED) ? PS'(MAX_PRODUCED) : PS'(pcnt_q);
	assign nc = (32'(ccnt_q) > MAX_CONSUMED) ? CS'(MAX_CONSUMED) : CS'(ccnt_q);

	logic [63:0] rdv;
	assign rdv = rd_v_q ? rd_q : 64'd0;
	logic p_scan_ent, c_scan_ent;
	assign p_scan_ent = pscan_q < np;
	assign c_scan_ent = cscan_q < nc;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			etpc_pkg::ST_IDLE: if (in_valid) begin
				unique case (etpc_pkg::cmd_t'(cmd))
					etpc_pkg::CMD_TICK: state_d = etpc_pkg::ST_PSCAN;
					etpc_pkg::CMD_ID_CONS, etpc_pkg::CMD_ID_PROD,
					etpc_pkg::CMD_REPORT: state_d = etpc_pkg::ST_FIND;
					default: state_d = etpc_pkg::ST_IDLE;
				endcase
			end
			etpc_pkg::ST_PSCAN: begin
				if (!p_scan_ent) state_d = tx_q ? etpc_pkg::ST_CSCAN : etpc_pkg::ST_OUT1;
				else if (p_id_q[pscan_q[PW-1:0]] || p_rep_q[pscan_q[PW-1:0]])
					state_d = etpc_pkg::ST_PREAD;
			end
			etpc_pkg::ST_PREAD: state_d = tx_q ? etpc_pkg::ST_CSCAN : etpc_pkg::ST_OUT1;
			etpc_pkg::ST_CSCAN: begin
				if (!c_scan_ent) state_d = etpc_pkg::ST_OUT1;
				else if (c_id_q[cscan_q[CW-1:0]]) state_d = etpc_pkg::ST_CREAD;
			end
			etpc_pkg::ST_CREAD: state_d = etpc_pkg::ST_OUT1;
			etpc_pkg::ST_FIND: begin
				if (cmd_q == etpc_pkg::CMD_ID_PROD) begin
					if (ptr_q >= 9'(np)) state_d = etpc_pkg::ST_IDLE;
					else state_d = etpc_pkg::ST_FCHK;
				end else begin
					if (ptr_q >= 9'(nc)) state_d = etpc_pkg::ST_IDLE;
					else state_d = etpc_pkg::ST_FCHK;
				end
			end
			etpc_pkg::ST_FCHK: begin
				if (rdv == ev_q)
					state_d = (cmd_q == etpc_pkg::CMD_REPORT) ? etpc_pkg::ST_OUT1
						: etpc_pkg::ST_MARK;
				else state_d = etpc_pkg::ST_FIND;
			end
			etpc_pkg::ST_MARK: state_d = etpc_pkg::ST_IDLE;
			etpc_pkg::ST_OUT1: begin
				if (!have1_q) state_d = have2_q ? etpc_pkg::ST_OUT2 : etpc_pkg::ST_IDLE;
				else if (out_ready) state_d = have2_q ? etpc_pkg::ST_OUT2 : etpc_pkg::ST_IDLE;
			end
			etpc_pkg::ST_OUT2: if (out_ready) state_d = etpc_pkg::ST_IDLE;
			default: state_d = etpc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == etpc_pkg::ST_IDLE);
		out_valid = 1'b0;
		message_kind = k1_q;
		message_index = i1_q;
		message_event = e1_q;
		last = !have2_q;
		unique case (state_q)
			etpc_pkg::ST_OUT1: out_valid = have1_q;
			etpc_pkg::ST_OUT2: begin
				out_valid = 1'b1;
				message_kind = k2_q;
				message_index = i2_q;
				message_event = e2_q;
				last = 1'b1;
			end
			default: ;
		endcase
	end

	logic acc;
	assign acc = in_valid && in_ready;

	// table memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (acc && cmd == etpc_pkg::CMD_WR_PROD && 32'(entry_index) < MAX_PRODUCED)
			prod_mem[entry_index[PW-1:0]] <= event_id;
		if (acc && cmd == etpc_pkg::CMD_WR_CONS && 32'(entry_index) < MAX_CONSUMED)
			cons_mem[entry_index[CW-1:0]] <= event_id;
		if (state_q == etpc_pkg::ST_PSCAN)
			rd_q <= prod_mem[pscan_q[PW-1:0]];
		else if (state_q == etpc_pkg::ST_CSCAN)
			rd_q <= cons_mem[cscan_q[CW-1:0]];
		else if (cmd_q == etpc_pkg::CMD_ID_PROD)
			rd_q <= prod_mem[ptr_q[PW-1:0]];
		else
			rd_q <= cons_mem[ptr_q[CW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etpc_pkg::ST_IDLE;
			p_val_q <= '0; p_id_q <= '0; p_rep_q <= '0;
			c_val_q <= '0; c_id_q <= '0;
			pscan_q <= '0; cscan_q <= '0;
			node_q <= '0; pcnt_q <= '0; ccnt_q <= '0;
			have1_q <= 1'b0; have2_q <= 1'b0;
			cmd_q <= etpc_pkg::CMD_TICK;
			ptr_q <= '0; rd_v_q <= 1'b0; tx_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (etpc_pkg::reg_idx_t'(cfg_index))
					etpc_pkg::REG_NODE_ID: node_q <= cfg_data;
					etpc_pkg::REG_PROD_CNT: pcnt_q <= cfg_data[5:0];
					etpc_pkg::REG_CONS_CNT: ccnt_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			unique case (state_q)
				etpc_pkg::ST_IDLE: if (acc) begin
					cmd_q <= etpc_pkg::cmd_t'(cmd);
					ev_q <= event_id;
					tx_q <= tx_ready;
					ptr_q <= '0;
					have1_q <= 1'b0;
					have2_q <= 1'b0;
					unique case (etpc_pkg::cmd_t'(cmd))
						etpc_pkg::CMD_PRODUCE: if (32'(entry_index) < MAX_PRODUCED) begin
							p_rep_q[entry_index[PW-1:0]] <= 1'b1;
							if (PS'(entry_index) < pscan_q) pscan_q <= PS'(entry_index);
						end
						etpc_pkg::CMD_WR_PROD: if (32'(entry_index) < MAX_PRODUCED) begin
							p_id_q[entry_index[PW-1:0]] <= 1'b1;
							p_val_q[entry_index[PW-1:0]] <= 1'b1;
						end
						etpc_pkg::CMD_WR_CONS: if (32'(entry_index) < MAX_CONSUMED) begin
							c_id_q[entry_index[CW-1:0]] <= 1'b1;
							c_val_q[entry_index[CW-1:0]] <= 1'b1;
						end
						etpc_pkg::CMD_ID_EVENTS: if (frame_node_id == node_q) begin
							for (int i = 0; i < MAX_PRODUCED; i++)
								if (i < int'(np)) p_id_q[i] <= 1'b1;
							for (int i = 0; i < MAX_CONSUMED; i++)
								if (i < int'(nc)) c_id_q[i] <= 1'b1;
							pscan_q <= '0;
							cscan_q <= '0;
						end
						default: ;
					endcase
				end
				etpc_pkg::ST_PSCAN: if (p_scan_ent) begin
					pscan_q <= pscan_q + 1'b1;
					rd_v_q <= p_val_q[pscan_q[PW-1:0]];
					i1_q <= 5'(pscan_q[PW-1:0]);
					if (p_id_q[pscan_q[PW-1:0]]) begin
						p_id_q[pscan_q[PW-1:0]] <= 1'b0;
						k1_q <= etpc_pkg::MSG_PROD_ID;
					end else if (p_rep_q[pscan_q[PW-1:0]]) begin
						p_rep_q[pscan_q[PW-1:0]] <= 1'b0;
						k1_q <= etpc_pkg::MSG_REPORT;
					end
				end
				etpc_pkg::ST_PREAD: begin
					have1_q <= 1'b1;
					e1_q <= rdv;
				end
				etpc_pkg::ST_CSCAN: if (c_scan_ent) begin
					cscan_q <= cscan_q + 1'b1;
					rd_v_q <= c_val_q[cscan_q[CW-1:0]];
					if (c_id_q[cscan_q[CW-1:0]]) begin
						c_id_q[cscan_q[CW-1:0]] <= 1'b0;
						if (have1_q) begin
							k2_q <= etpc_pkg::MSG_CONS_ID;
							i2_q <= 5'(cscan_q[CW-1:0]);
						end else begin
							k1_q <= etpc_pkg::MSG_CONS_ID;
							i1_q <= 5'(cscan_q[CW-1:0]);
						end
					end
				end
				etpc_pkg::ST_CREAD: begin
					if (have1_q) begin
						have2_q <= 1'b1;
						e2_q <= rdv;
					end else begin
						have1_q <= 1'b1;
						e1_q <= rdv;
					end
				end
				etpc_pkg::ST_FIND: begin
					rd_v_q <= (cmd_q == etpc_pkg::CMD_ID_PROD)
						? p_val_q[ptr_q[PW-1:0]] : c_val_q[ptr_q[CW-1:0]];
					ptr_q <= ptr_q + 1'b1;
				end
				etpc_pkg::ST_FCHK: if (rdv == ev_q) begin
					ptr_q <= ptr_q - 1'b1;
					if (cmd_q == etpc_pkg::CMD_REPORT) begin
						have1_q <= 1'b1;
						k1_q <= etpc_pkg::MSG_NOTIFY;
						i1_q <= 5'(ptr_q - 1'b1);
						e1_q <= rdv;
					end
				end
				etpc_pkg::ST_MARK: begin
					if (cmd_q == etpc_pkg::CMD_ID_PROD) begin
						p_id_q[ptr_q[PW-1:0]] <= 1'b1;
						if (PS'(ptr_q) < pscan_q) pscan_q <= PS'(ptr_q);
					end else begin
						c_id_q[ptr_q[CW-1:0]] <= 1'b1;
						if (CS'(ptr_q) < cscan_q) cscan_q <= CS'(ptr_q);
					end
				end
				default: ;
			endcase
		end
	end

	`ETPC_ASSERT_IMP(a_busy_no_accept, state_q != etpc_pkg::ST_IDLE, !in_ready)
	`ETPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(message_event))
	`ETPC_ASSERT_IMP(a_second_last, state_q == etpc_pkg::ST_OUT2, last && have1_q)
endmodule

// ----- test/tb_event_table_producer_consumer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_table_producer_consumer
// Drives commands into the event table block under random handshake gaps,
// predicts every message from a local copy of the tables, scan pointers and
// registers, and compares each output transaction in order.
// ----------------------------------------------------------------------------
module tb_event_table_producer_consumer;
	import etpc_pkg::*;

	typedef struct packed {
		msg_kind_t   kind;
		logic [4:0]  index;
		logic [63:0] ev;
		logic        last;
	} message_t;

	localparam int TABLE_SIZE = 32;
	localparam int DRAIN_CYCLES = 150;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_index = REG_NODE_ID;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	cmd_t        cmd = CMD_TICK;
	logic [4:0]  entry_index = '0;
	logic [63:0] event_id = '0;
	logic [47:0] frame_node_id = '0;
	logic        tx_ready = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  message_kind;
	logic [4:0]  message_index;
	logic [63:0] message_event;
	logic        last;

	event_table_producer_consumer uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.entry_index(entry_index), .event_id(event_id), .frame_node_id(frame_node_id),
		.tx_ready(tx_ready), .out_valid(out_valid), .out_ready(out_ready),
		.message_kind(message_kind), .message_index(message_index),
		.message_event(message_event), .last(last)
	);

	always #10 clk = ~clk;

	// local copy of the block state
	logic [47:0] node_id_q;
	logic [5:0]  prod_count_q, cons_count_q;
	logic [63:0] prod_ids [TABLE_SIZE];
	logic [63:0] cons_ids [TABLE_SIZE];
	logic        prod_ident [TABLE_SIZE];
	logic        prod_report [TABLE_SIZE];
	logic        cons_ident [TABLE_SIZE];
	int          prod_scan, cons_scan;

	message_t    pending_msgs[$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          gaps_on = 1'b1;
	logic [63:0] id_pool [8];

	function automatic int clamp_count(logic [5:0] c);
		return (c > TABLE_SIZE) ? TABLE_SIZE : int'(c);
	endfunction

	function automatic int find_id(ref logic [63:0] tab [TABLE_SIZE], input int n,
			input logic [63:0] ev);
		for (int i = 0; i < n; i++)
			if (tab[i] == ev) return i;
		return -1;
	endfunction

	task automatic predict_messages(cmd_t c, logic [4:0] ix, logic [63:0] ev,
			logic [47:0] nd, logic tr);
		int np, nc, hit, s;
		message_t m [$];
		message_t one;
		np = clamp_count(prod_count_q);
		nc = clamp_count(cons_count_q);
		case (c)
			CMD_TICK: begin
				while (prod_scan < np) begin
					s = prod_scan;
					prod_scan++;
					if (prod_ident[s]) begin
						prod_ident[s] = 1'b0;
						m.push_back('{MSG_PROD_ID, s[4:0], prod_ids[s], 1'b0});
						break;
					end else if (prod_report[s]) begin
						prod_report[s] = 1'b0;
						m.push_back('{MSG_REPORT, s[4:0], prod_ids[s], 1'b0});
						break;
					end
				end
				if (tr) begin
					while (cons_scan < nc) begin
						s = cons_scan;
						cons_scan++;
						if (cons_ident[s]) begin
							cons_ident[s] = 1'b0;
							m.push_back('{MSG_CONS_ID, s[4:0], cons_ids[s], 1'b0});
							break;
						end
					end
				end
			end
			CMD_PRODUCE: begin
				prod_report[ix] = 1'b1;
				if (int'(ix) < prod_scan) prod_scan = int'(ix);
			end
			CMD_WR_PROD: begin
				prod_ids[ix] = ev;
				prod_ident[ix] = 1'b1;
			end
			CMD_WR_CONS: begin
				cons_ids[ix] = ev;
				cons_ident[ix] = 1'b1;
			end
			CMD_ID_CONS: begin
				hit = find_id(cons_ids, nc, ev);
				if (hit >= 0) begin
					cons_ident[hit] = 1'b1;
					if (hit < cons_scan) cons_scan = hit;
				end
			end
			CMD_ID_PROD: begin
				hit = find_id(prod_ids, np, ev);
				if (hit >= 0) begin
					prod_ident[hit] = 1'b1;
					if (hit < prod_scan) prod_scan = hit;
				end
			end
			CMD_ID_EVENTS: begin
				if (nd == node_id_q) begin
					for (int i = 0; i < np; i++) prod_ident[i] = 1'b1;
					for (int i = 0; i < nc; i++) cons_ident[i] = 1'b1;
					prod_scan = 0;
					cons_scan = 0;
				end
			end
			default: begin
				hit = find_id(cons_ids, nc, ev);
				if (hit >= 0) m.push_back('{MSG_NOTIFY, hit[4:0], cons_ids[hit], 1'b0});
			end
		endcase
		for (int k = 0; k < m.size(); k++) begin
			one = m[k];
			one.last = (k == m.size() - 1);
			pending_msgs.push_back(one);
		end
	endtask

	task automatic send_command(cmd_t c, logic [4:0] ix, logic [63:0] ev,
			logic [47:0] nd, logic tr);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		entry_index <= ix;
		event_id <= ev;
		frame_node_id <= nd;
		tx_ready <= tr;
		do @(posedge clk); while (!in_ready);
		predict_messages(c, ix, ev, nd, tr);
	endtask

	// hold off until the block is idle, then write one register
	task automatic write_register(reg_idx_t r, logic [47:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_msgs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_NODE_ID:  node_id_q = value;
			REG_PROD_CNT: prod_count_q = value[5:0];
			default:      cons_count_q = value[5:0];
		endcase
	endtask

	task automatic send_random(bit well_formed);
		cmd_t c;
		logic [63:0] ev;
		logic [47:0] nd;
		c = cmd_t'($urandom_range(0, 7));
		if ($urandom_range(0, 2) == 0) c = CMD_TICK;
		ev = well_formed ? id_pool[$urandom_range(0, 7)] : {$urandom, $urandom};
		nd = ($urandom_range(0, 3) == 0) ? node_id_q : 48'({$urandom, $urandom});
		send_command(c, 5'($urandom_range(0, 31)), ev, nd, $urandom_range(0, 3) != 0);
	endtask

	task automatic test_directed();
		write_register(REG_NODE_ID, 48'hFFFF_FFFF_FFFF);
		write_register(REG_PROD_CNT, 48'd32);
		write_register(REG_CONS_CNT, 48'd32);
		send_command(CMD_WR_PROD, 5'd0, '1, '0, 1'b1);
		send_command(CMD_WR_PROD, 5'd31, '0, '0, 1'b1);
		send_command(CMD_WR_CONS, 5'd0, 64'hA5A5_5A5A_0F0F_F0F0, '0, 1'b1);
		send_command(CMD_WR_CONS, 5'd31, '1, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b0);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_PRODUCE, 5'd0, '0, '0, 1'b1);
		send_command(CMD_PRODUCE, 5'd31, '0, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_ID_PROD, '0, '1, '0, 1'b1);
		send_command(CMD_ID_PROD, '0, 64'h1234, '0, 1'b1);
		send_command(CMD_ID_CONS, '0, '1, '0, 1'b1);
		send_command(CMD_ID_CONS, '0, 64'h1234, '0, 1'b1);
		send_command(CMD_REPORT, '0, 64'hA5A5_5A5A_0F0F_F0F0, '0, 1'b1);
		send_command(CMD_REPORT, '0, 64'h1234, '0, 1'b1);
		send_command(CMD_ID_EVENTS, '0, '0, 48'h0, 1'b1);
		send_command(CMD_ID_EVENTS, '0, '0, 48'hFFFF_FFFF_FFFF, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b0);
		// entry above the count stays hidden until the count grows
		write_register(REG_PROD_CNT, 48'd4);
		send_command(CMD_WR_PROD, 5'd20, 64'h55, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		write_register(REG_PROD_CNT, 48'd63);
		write_register(REG_CONS_CNT, 48'd0);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
		send_command(CMD_TICK, '0, '0, '0, 1'b1);
	endtask

	task automatic test_random_phases();
		logic [5:0] counts [6] = '{6'd32, 6'd0, 6'd63, 6'd5, 6'd17, 6'd1};
		for (int p = 0; p < 6; p++) begin
			for (int i = 0; i < 8; i++) id_pool[i] = {$urandom, $urandom};
			write_register(REG_NODE_ID, 48'({$urandom, $urandom}));
			write_register(REG_PROD_CNT, 48'(counts[p]));
			write_register(REG_CONS_CNT, 48'(counts[5 - p]));
			gaps_on = (p % 3 != 2);
			for (int i = 0; i < 200; i++) send_random($urandom_range(0, 9) != 0);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 60; i++) begin
			send_random(1'b1);
			if (i == 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_msgs.size() != 0) @(posedge clk);
			end
		end
	endtask

	// output side: random stalls per transaction
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = $urandom_range(0, 6);
			if (wait_cycles > 0 && gaps_on) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		message_t exp_m;
		if (out_valid && out_ready) begin
			if (pending_msgs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected message kind=%0d index=%0d event=%h last=%b",
						message_kind, message_index, message_event, last);
			end else begin
				exp_m = pending_msgs.pop_front();
				if (message_kind !== exp_m.kind || message_index !== exp_m.index ||
						message_event !== exp_m.ev || last !== exp_m.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
							exp_m.kind, exp_m.index, exp_m.ev, exp_m.last,
							message_kind, message_index, message_event, last);
				end
			end
		end
	end

	// watchdog: no transaction for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_event_table_producer_consumer: done, errors");
			$finish;
		end
	end

	initial begin
		node_id_q = '0;
		prod_count_q = '0;
		cons_count_q = '0;
		prod_scan = 0;
		cons_scan = 0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			prod_ids[i] = '0;
			cons_ids[i] = '0;
			prod_ident[i] = 1'b0;
			prod_report[i] = 1'b0;
			cons_ident[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_drain_pause();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_msgs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_msgs.size() == 0)
			$display("tb_event_table_producer_consumer: done, clean");
		else
			$display("tb_event_table_producer_consumer: done, errors");
		$finish;
	end
endmodule

// ----- event_table_producer_consumer.f -----
+incdir+rtl
rtl/etpc_pkg.sv
rtl/event_table_producer_consumer.sv
test/tb_event_table_producer_consumer.sv
